>>> rtl/mmfc_pkg.sv
`default_nettype none
package mmfc_pkg;

	// Stream item kinds
	localparam logic CMD_FEEDBACK = 1'b0;
	localparam logic CMD_TICK     = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ENABLE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_OUTER    = 3'd5;

	// Control laws
	typedef enum logic [1:0] {
		MODE_VEL_PD  = 2'd0,
		MODE_VEL_PI  = 2'd1,
		MODE_CASCADE = 2'd2,
		MODE_POS_PI  = 2'd3
	} loop_mode_t;

	// Limits
	localparam int WRAP_JUMP   = 4000;
	localparam int VERR_LIMIT  = 1000;
	localparam int DERR_LIMIT  = 500;
	localparam int PERR_LIMIT  = 4000;
	localparam int INTEG_LIMIT = 16667;
	localparam int CUR_LIMIT   = 15000;

	// Shared multiplier operand widths
	localparam int MA_W   = 29;
	localparam int MB_W   = 33;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = 44;
	localparam int Y_W    = 28;

	// Reciprocals: floor(y/10) = (y*RECIP10)>>31, floor(y/100) = (y*RECIP100)>>27
	localparam logic [MA_W-1:0] RECIP10   = 29'd214748365;
	localparam int              RECIP10_SH = 31;
	localparam logic [MA_W-1:0] RECIP100  = 29'd1342178;
	localparam int              RECIP100_SH = 27;

	// Sequencer
	localparam int STEP_W = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_POST,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic              ready;
		logic              prep;
		logic              mul;
		logic              post;
		logic              out_load;
		logic [STEP_W-1:0] step;
	} seq_ctrl_t;

	// What a step does with its product
	typedef enum logic [2:0] {
		POP_ACC_SET,
		POP_ACC_ADD,
		POP_Y_SET,
		POP_ACC_DIV10,
		POP_VEL_DIV100
	} post_op_t;

	// Signed divide by 256, truncating toward zero
	function automatic logic signed [PROD_W-9:0] trunc_div256(input logic signed [PROD_W-1:0] x);
		logic signed [PROD_W-1:0] biased;
		biased = x + (x[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
		return biased[PROD_W-1:8];
	endfunction

endpackage
`default_nettype wire

>>> rtl/multi_motor_feedback_and_current_loop.sv
`default_nettype none
// Multi-motor feedback tracker and drive-current loop. Feedback requests
// (tuser=0) carry a bus id, 13-bit angle and signed speed; ids
// FIRST_MOTOR_ID..FIRST_MOTOR_ID+MOTOR_COUNT-1 update that motor's turn count
// (a jump above 4000 counts adds or removes a turn) and return the multi-turn
// position, other ids return bad_frame. Tick requests (tuser=1) run the loop
// selected by loop_mode for one motor and return the drive current, clamped
// to +-15000 and zero while drive_enable is low. One request is in work at a
// time; a tick makes N passes through the single shared multiplier (N = 2 in
// modes 0 and 3, 3 in mode 1, 5 in mode 2), each pass being a multiply state
// and a registered post-processing state. A finished result sits in the output
// register while the next request is taken.
// Configuration writes are to be made only while the block is idle.
module multi_motor_feedback_and_current_loop
	import mmfc_pkg::*;
#(
	parameter int MOTOR_COUNT    = 4,
	parameter int FIRST_MOTOR_ID = 513
) (
	input  wire          clk,
	input  wire          arst_n,
	// tdata: frame_id[10:0], motor_sel[12:11], encoder_angle[25:13],
	//        measured_speed[41:26], target_value[73:42], zero fill
	input  wire  [79:0]  s_tdata,
	// tuser: command
	input  wire  [0:0]   s_tuser,
	input  wire          s_tvalid,
	output logic         s_tready,
	// tdata: motor_out[1:0], unwrapped_position[31:2], drive_current[46:32],
	//        zero fill
	output logic [47:0]  m_tdata,
	// tuser: result_kind[0], bad_frame[1]
	output logic [1:0]   m_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [15:0]  cfg_data
);

	localparam int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	seq_ctrl_t ctrl;

	// Configuration registers
	loop_mode_t  mode_q;
	logic        enable_q;
	logic [15:0] kp_q, ki_q, kd_q, ko_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_VEL_PD;
			enable_q <= 1'b1;
			kp_q     <= 16'd3328;
			ki_q     <= 16'd1536;
			kd_q     <= 16'd2560;
			ko_q     <= 16'd3840;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOOP_MODE:     mode_q   <= loop_mode_t'(cfg_data[1:0]);
				REG_DRIVE_ENABLE:  enable_q <= cfg_data[0];
				REG_GAIN_PROP:     kp_q     <= cfg_data;
				REG_GAIN_INTEGRAL: ki_q     <= cfg_data;
				REG_GAIN_DERIV:    kd_q     <= cfg_data;
				REG_GAIN_OUTER:    ko_q     <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Request capture
	logic               cmd_q;
	logic [10:0]        fid_q;
	logic [1:0]         sel_q;
	logic [12:0]        ang_q;
	logic signed [15:0] spd_q;
	logic signed [31:0] tgt_q;

	assign s_tready = ctrl.ready;

	always_ff @(posedge clk) begin
		if (s_tvalid && ctrl.ready) begin
			cmd_q <= s_tuser[0];
			fid_q <= s_tdata[10:0];
			sel_q <= s_tdata[12:11];
			ang_q <= s_tdata[25:13];
			spd_q <= s_tdata[41:26];
			tgt_q <= s_tdata[73:42];
		end
	end

	// Per-motor state
	logic [12:0]        last_angle_q [MOTOR_COUNT];
	logic signed [15:0] turn_q       [MOTOR_COUNT];
	logic               seen_q       [MOTOR_COUNT];
	logic signed [15:0] speed_q      [MOTOR_COUNT];
	logic signed [10:0] prev_err_q   [MOTOR_COUNT];
	logic signed [31:0] integ_q      [MOTOR_COUNT];

	// Motor decode
	logic [11:0]   fid_off;
	logic          fb_good, tick_good;
	logic [IW-1:0] idx, idx_q;

	assign fid_off   = {1'b0, fid_q} - 12'(FIRST_MOTOR_ID);
	assign fb_good   = ({1'b0, fid_q} >= 12'(FIRST_MOTOR_ID)) && (fid_off < 12'(MOTOR_COUNT));
	assign tick_good = 4'(sel_q) < 4'(MOTOR_COUNT);
	assign idx       = (cmd_q == CMD_TICK) ? IW'(sel_q) : IW'(fid_off);

	// Feedback unwrap
	logic signed [13:0] ang_diff;
	logic signed [15:0] turn_new;
	logic signed [29:0] fb_pos;

	always_comb begin
		ang_diff = $signed({1'b0, ang_q}) - $signed({1'b0, last_angle_q[idx]});
		turn_new = turn_q[idx];
		if (seen_q[idx]) begin
			if (ang_diff < -14'sd4000) turn_new = turn_q[idx] + 16'sd1;
			else if (ang_diff > 14'sd4000) turn_new = turn_q[idx] - 16'sd1;
		end
		fb_pos = {turn_new[15], turn_new, 13'd0} + {17'd0, ang_q};
	end

	// Tick error terms
	logic signed [29:0] cur_pos;
	logic signed [32:0] verr;
	logic signed [10:0] e0;
	logic signed [11:0] derr;
	logic signed [9:0]  d0;
	logic signed [32:0] i1_sum;
	logic signed [31:0] i1;
	logic signed [32:0] perr;
	logic signed [12:0] pclamp;
	logic signed [33:0] s3_sum;
	logic signed [31:0] s3;

	always_comb begin
		cur_pos = {turn_q[idx][15], turn_q[idx], 13'd0} + {17'd0, last_angle_q[idx]};
		verr    = 33'(tgt_q) - 33'(speed_q[idx]);
		if (verr > 33'sd1000) e0 = 11'sd1000;
		else if (verr < -33'sd1000) e0 = -11'sd1000;
		else e0 = verr[10:0];
		derr = 12'(e0) - 12'(prev_err_q[idx]);
		if (derr > 12'sd500) d0 = 10'sd500;
		else if (derr < -12'sd500) d0 = -10'sd500;
		else d0 = derr[9:0];
		i1_sum = 33'(integ_q[idx]) + 33'(e0);
		if (i1_sum > 33'sd16667) i1 = 32'sd16667;
		else if (i1_sum < -33'sd16667) i1 = -32'sd16667;
		else i1 = i1_sum[31:0];
		perr = 33'(tgt_q) - 33'(cur_pos);
		if (perr > 33'sd4000) pclamp = 13'sd4000;
		else if (perr < -33'sd4000) pclamp = -13'sd4000;
		else pclamp = perr[12:0];
		s3_sum = 34'(integ_q[idx]) + 34'(perr);
		if (s3_sum > 34'sd2147483647) s3 = 32'sh7fffffff;
		else if (s3_sum < -34'sd2147483648) s3 = 32'sh80000000;
		else s3 = s3_sum[31:0];
	end

	// Working registers
	logic signed [10:0]   e_q;
	logic signed [9:0]    d_q;
	logic signed [32:0]   p_q;
	logic signed [Y_W-1:0] y_q;
	logic signed [17:0]   e2_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [1:0]           res_motor_q;
	logic signed [29:0]   res_pos_q;
	logic                 res_bad_q;

	// Step table
	logic signed [MA_W-1:0] op_a;
	logic signed [MB_W-1:0] op_b;
	post_op_t               pop;
	logic                   last_step;
	logic [Y_W-2:0]         y_mag;
	logic [21:0]            kp50;
	logic [20:0]            ki19;

	assign y_mag = y_q[Y_W-1] ? (Y_W-1)'(-y_q) : y_q[Y_W-2:0];
	assign kp50  = {1'b0, kp_q, 5'd0} + {2'd0, kp_q, 4'd0} + {5'd0, kp_q, 1'd0};
	assign ki19  = {1'b0, ki_q, 4'd0} + {4'd0, ki_q, 1'd0} + {5'd0, ki_q};

	always_comb begin
		op_a      = MA_W'({1'b0, kp_q});
		op_b      = MB_W'(e_q);
		pop       = POP_ACC_SET;
		last_step = 1'b0;
		case (mode_q)
			MODE_VEL_PD: begin
				if (ctrl.step != '0) begin
					op_a      = MA_W'({1'b0, kd_q});
					op_b      = MB_W'(d_q);
					pop       = POP_ACC_ADD;
					last_step = 1'b1;
				end
			end
			MODE_VEL_PI: begin
				case (ctrl.step)
					3'd0: ;
					3'd1: begin
						op_a = MA_W'({1'b0, ki_q});
						op_b = MB_W'(integ_q[idx_q]);
						pop  = POP_Y_SET;
					end
					default: begin
						op_a      = RECIP10;
						op_b      = MB_W'({1'b0, y_mag});
						pop       = POP_ACC_DIV10;
						last_step = 1'b1;
					end
				endcase
			end
			MODE_CASCADE: begin
				case (ctrl.step)
					3'd0: begin
						op_a = MA_W'({1'b0, ko_q});
						op_b = p_q;
						pop  = POP_Y_SET;
					end
					3'd1: begin
						op_a = RECIP100;
						op_b = MB_W'({1'b0, y_mag});
						pop  = POP_VEL_DIV100;
					end
					3'd2: begin
						op_a = MA_W'({1'b0, kp50});
						op_b = MB_W'(e2_q);
					end
					3'd3: begin
						op_a = MA_W'({1'b0, ki19});
						op_b = MB_W'(integ_q[idx_q]);
						pop  = POP_Y_SET;
					end
					default: begin
						op_a      = RECIP10;
						op_b      = MB_W'({1'b0, y_mag});
						pop       = POP_ACC_DIV10;
						last_step = 1'b1;
					end
				endcase
			end
			default: begin
				op_b = p_q;
				if (ctrl.step != '0) begin
					op_a      = MA_W'({1'b0, ki_q});
					op_b      = MB_W'(integ_q[idx_q]);
					pop       = POP_ACC_ADD;
					last_step = 1'b1;
				end
			end
		endcase
	end

	logic signed [PROD_W-1:0] prod_q;

	mmfc_mul u_mul (
		.clk    (clk),
		.en     (ctrl.mul),
		.a      (op_a),
		.b      (op_b),
		.prod_q (prod_q)
	);

	mmfc_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.go_mul    ((cmd_q == CMD_TICK) && tick_good),
		.last_step (last_step),
		.out_free  (!m_tvalid || m_tready),
		.ctrl      (ctrl)
	);

	// Post-processing of the product
	logic signed [PROD_W-9:0] t256;
	logic [24:0]              q10;
	logic [14:0]              q100;
	logic signed [15:0]       vel;
	logic signed [17:0]       e2;
	logic signed [33:0]       i2_sum;
	logic signed [31:0]       i2;

	always_comb begin
		t256   = trunc_div256(prod_q);
		q10    = prod_q[RECIP10_SH+24:RECIP10_SH];
		q100   = prod_q[RECIP100_SH+14:RECIP100_SH];
		vel    = y_q[Y_W-1] ? -$signed({1'b0, q100}) : $signed({1'b0, q100});
		e2     = 18'(vel) - 18'(speed_q[idx_q]);
		i2_sum = 34'(integ_q[idx_q]) + 34'(e2);
		if (i2_sum > 34'sd16667) i2 = 32'sd16667;
		else if (i2_sum < -34'sd16667) i2 = -32'sd16667;
		else i2 = i2_sum[31:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.prep) begin
			idx_q     <= idx;
			e_q       <= e0;
			d_q       <= d0;
			p_q       <= (mode_q == MODE_CASCADE) ? 33'(pclamp) : perr;
			acc_q     <= '0;
			res_bad_q <= 1'b0;
			res_pos_q <= '0;
			if (cmd_q == CMD_TICK) begin
				res_motor_q <= sel_q;
			end else if (fb_good) begin
				res_motor_q <= 2'(fid_off);
				res_pos_q   <= fb_pos;
			end else begin
				res_motor_q <= 2'd0;
				res_bad_q   <= 1'b1;
			end
		end else if (ctrl.post) begin
			case (pop)
				POP_ACC_SET:    acc_q <= ACC_W'(t256);
				POP_ACC_ADD:    acc_q <= acc_q + ACC_W'(t256);
				POP_Y_SET:      y_q   <= Y_W'(t256);
				POP_ACC_DIV10:  acc_q <= y_q[Y_W-1] ? acc_q - ACC_W'(q10)
				                                    : acc_q + ACC_W'(q10);
				POP_VEL_DIV100: e2_q  <= e2;
				default:        ;
			endcase
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				last_angle_q[i] <= '0;
				turn_q[i]       <= '0;
				seen_q[i]       <= 1'b0;
				speed_q[i]      <= '0;
				prev_err_q[i]   <= '0;
				integ_q[i]      <= '0;
			end
		end else if (ctrl.prep) begin
			if (cmd_q == CMD_FEEDBACK && fb_good) begin
				last_angle_q[idx] <= ang_q;
				turn_q[idx]       <= turn_new;
				seen_q[idx]       <= 1'b1;
				speed_q[idx]      <= spd_q;
			end else if (cmd_q == CMD_TICK && tick_good) begin
				case (mode_q)
					MODE_VEL_PD:  prev_err_q[idx] <= e0;
					MODE_VEL_PI:  integ_q[idx]    <= i1;
					MODE_POS_PI:  integ_q[idx]    <= s3;
					default:      ;
				endcase
			end
		end else if (ctrl.post && pop == POP_VEL_DIV100) begin
			integ_q[idx_q] <= i2;
		end
	end

	// Result register
	logic signed [14:0] cur;

	always_comb begin
		if (acc_q > ACC_W'(CUR_LIMIT)) cur = 15'sd15000;
		else if (acc_q < -ACC_W'(CUR_LIMIT)) cur = -15'sd15000;
		else cur = acc_q[14:0];
		if (!enable_q || cmd_q == CMD_FEEDBACK) cur = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ctrl.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			m_tdata <= {1'b0, cur, res_pos_q, res_motor_q};
			m_tuser <= {res_bad_q, cmd_q};
		end
	end

endmodule
`default_nettype wire

>>> rtl/mmfc_mul.sv
`default_nettype none
module mmfc_mul
	import mmfc_pkg::*;
(
	input  wire                       clk,
	input  wire                       en,
	input  wire logic signed [MA_W-1:0]   a,
	input  wire logic signed [MB_W-1:0]   b,
	output logic signed [PROD_W-1:0]  prod_q
);

	// Shared signed multiplier, product registered
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

endmodule
`default_nettype wire

>>> rtl/mmfc_fsm.sv
`default_nettype none
module mmfc_fsm
	import mmfc_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        go_mul,
	input  wire        last_step,
	input  wire        out_free,
	output seq_ctrl_t  ctrl
);

	seq_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_PREP;
			ST_PREP: state_d = go_mul ? ST_MUL : ST_DONE;
			ST_MUL:  state_d = ST_POST;
			ST_POST: state_d = last_step ? ST_DONE : ST_MUL;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PREP) begin
				step_q <= '0;
			end else if (state_q == ST_POST) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Outputs
	always_comb begin
		ctrl          = '0;
		ctrl.step     = step_q;
		case (state_q)
			ST_IDLE: ctrl.ready    = 1'b1;
			ST_PREP: ctrl.prep     = 1'b1;
			ST_MUL:  ctrl.mul      = 1'b1;
			ST_POST: ctrl.post     = 1'b1;
			ST_DONE: ctrl.out_load = out_free;
			default: ctrl.ready    = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

>>> verif/tb_multi_motor_feedback_and_current_loop.sv
`default_nettype none

class motor_scoreboard;
	// Loop settings
	logic [1:0]  mode;
	logic        enable;
	logic [15:0] kp, ki, kd, ko;
	// Per-motor history
	logic [12:0] last_angle [4];
	logic [15:0] turns [4];
	bit          seen [4];
	longint      speed [4];
	longint      prev_err [4];
	longint      integ [4];
	// Expected results: {bad, current, position, motor, kind}
	logic [49:0] pending [$];
	int          errors;
	int          results;

	function new();
		mode = mmfc_pkg::MODE_VEL_PD;
		enable = 1'b1;
		kp = 16'd3328;
		ki = 16'd1536;
		kd = 16'd2560;
		ko = 16'd3840;
		for (int i = 0; i < 4; i++) begin
			last_angle[i] = '0;
			turns[i] = '0;
			seen[i] = 0;
			speed[i] = 0;
			prev_err[i] = 0;
			integ[i] = 0;
		end
		errors = 0;
		results = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
			mmfc_pkg::REG_LOOP_MODE:     mode = val[1:0];
			mmfc_pkg::REG_DRIVE_ENABLE:  enable = val[0];
			mmfc_pkg::REG_GAIN_PROP:     kp = val;
			mmfc_pkg::REG_GAIN_INTEGRAL: ki = val;
			mmfc_pkg::REG_GAIN_DERIV:    kd = val;
			mmfc_pkg::REG_GAIN_OUTER:    ko = val;
			default: ;
		endcase
	endfunction

	static function longint clip(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function longint position(int m);
		return longint'($signed(turns[m])) * 8192 + longint'(last_angle[m]);
	endfunction

	// Integer division in SV truncates toward zero, as the hardware does
	function longint control_law(int m, longint target);
		longint e, d, p, v, s;
		case (mode)
			mmfc_pkg::MODE_VEL_PD: begin
				e = clip(target - speed[m], 1000);
				d = clip(e - prev_err[m], 500);
				prev_err[m] = e;
				return (longint'(kp) * e) / 256 + (longint'(kd) * d) / 256;
			end
			mmfc_pkg::MODE_VEL_PI: begin
				e = clip(target - speed[m], 1000);
				integ[m] = clip(integ[m] + e, 16667);
				return (longint'(kp) * e) / 256 + (longint'(ki) * integ[m]) / 2560;
			end
			mmfc_pkg::MODE_CASCADE: begin
				p = clip(target - position(m), 4000);
				v = (longint'(ko) * p) / 25600;
				e = v - speed[m];
				integ[m] = clip(integ[m] + e, 16667);
				return (50 * longint'(kp) * e) / 256
					+ (19 * longint'(ki) * integ[m]) / 2560;
			end
			default: begin
				p = target - position(m);
				s = integ[m] + p;
				if (s > 64'sd2147483647) s = 64'sd2147483647;
				if (s < -64'sd2147483648) s = -64'sd2147483648;
				integ[m] = s;
				return (longint'(kp) * p) / 256 + (longint'(ki) * s) / 256;
			end
		endcase
	endfunction

	// Note an accepted request and queue what it must produce
	function void note_request(logic cmd, logic [10:0] fid, logic [1:0] sel,
			logic [12:0] ang, logic signed [15:0] spd, logic signed [31:0] tgt);
		logic [49:0] exp_item;
		longint diff, cur;
		int m;
		exp_item = '0;
		exp_item[0] = cmd;
		if (cmd == mmfc_pkg::CMD_FEEDBACK) begin
			if (fid < 11'd513 || fid > 11'd516) begin
				exp_item[49] = 1'b1;
			end else begin
				m = int'(fid - 11'd513);
				if (seen[m]) begin
					diff = longint'(ang) - longint'(last_angle[m]);
					if (diff < -4000) turns[m] = turns[m] + 16'd1;
					if (diff > 4000) turns[m] = turns[m] - 16'd1;
				end
				last_angle[m] = ang;
				seen[m] = 1;
				speed[m] = spd;
				exp_item[2:1] = 2'(m);
				exp_item[32:3] = 30'(position(m));
			end
		end else begin
			m = int'(sel);
			exp_item[2:1] = sel;
			cur = clip(control_law(m, tgt), 15000);
			if (!enable) cur = 0;
			exp_item[47:33] = 15'(cur);
		end
		pending.push_back(exp_item);
	endfunction

	function void check_result(logic [47:0] tdata, logic [1:0] tuser);
		logic [49:0] got, want;
		got = {tuser[1], 1'b0, tdata[46:32], tdata[31:2], tdata[1:0], tuser[0]};
		results++;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display({"result %0d: kind %0d/%0d motor %0d/%0d pos %0d/%0d",
					" cur %0d/%0d bad %0d/%0d"},
					results, want[0], got[0], want[2:1], got[2:1],
					$signed(want[32:3]), $signed(got[32:3]),
					$signed(want[47:33]), $signed(got[47:33]), want[49], got[49]);
		end
	endfunction
endclass

module tb_multi_motor_feedback_and_current_loop;
	import mmfc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [79:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic s_tvalid = 1'b0;
	wire s_tready;
	wire [47:0] m_tdata;
	wire [1:0] m_tuser;
	wire m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_valid = 1'b0;
	wire cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	motor_scoreboard board;
	int idle_cycles = 0;
	int requests;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multi_motor_feedback_and_current_loop dut (
		.clk, .arst_n, .s_tdata, .s_tuser, .s_tvalid, .s_tready,
		.m_tdata, .m_tuser, .m_tvalid, .m_tready,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	// Result side: random stall per result, check on accept
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_result(m_tdata, m_tuser);
		end
	end

	// Watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send(logic cmd, logic [10:0] fid, logic [1:0] sel, logic [12:0] ang,
			logic [15:0] spd, logic [31:0] tgt);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		repeat (gap) @(negedge clk);
		s_tdata <= {6'd0, tgt, spd, ang, sel, fid};
		s_tuser <= cmd;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_request(cmd, fid, sel, ang, spd, tgt);
		requests++;
		@(negedge clk) s_tvalid <= 1'b0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Let every queued result drain, then the loop latency
	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Feedback mostly close to the last angle so wraps stay meaningful
	task automatic feedback_rand();
		int m;
		logic [12:0] ang;
		logic [10:0] fid;
		m = $urandom_range(0, 3);
		if ($urandom_range(0, 9) == 0) fid = 11'($urandom);
		else fid = 11'(11'd513 + m);
		case ($urandom_range(0, 3))
			0: ang = 13'($urandom);
			default: ang = board.last_angle[m] + 13'($urandom_range(0, 600)) - 13'd300;
		endcase
		send(CMD_FEEDBACK, fid, 2'($urandom), ang, 16'($urandom), $urandom);
	endtask

	task automatic tick_rand();
		int m;
		logic [31:0] tgt;
		m = $urandom_range(0, 3);
		case ($urandom_range(0, 3))
			0: tgt = $urandom;
			1: tgt = $signed(32'($urandom_range(0, 4000))) - 2000;
			default: tgt = 32'(board.position(m) + $urandom_range(0, 20000) - 10000);
		endcase
		send(CMD_TICK, 11'($urandom), 2'(m), 13'($urandom), 16'($urandom), tgt);
	endtask

	initial begin
		board = new();
		requests = 0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: first frames, wraps both ways, bad ids, extremes
		send(CMD_FEEDBACK, 11'd513, 2'd3, 13'd8191, 16'h7fff, 32'h7fffffff);
		send(CMD_FEEDBACK, 11'd513, 2'd0, 13'd10, 16'h8000, 32'h80000000);
		send(CMD_FEEDBACK, 11'd513, 2'd0, 13'd8000, 16'd100, 32'd0);
		send(CMD_FEEDBACK, 11'd514, 2'd0, 13'd0, 16'hffff, 32'd0);
		send(CMD_FEEDBACK, 11'd516, 2'd0, 13'd4000, 16'd0, 32'd0);
		send(CMD_FEEDBACK, 11'd516, 2'd0, 13'd0, 16'd0, 32'd0);
		send(CMD_FEEDBACK, 11'd512, 2'd0, 13'd5, 16'd5, 32'd5);
		send(CMD_FEEDBACK, 11'd517, 2'd0, 13'd5, 16'd5, 32'd5);
		send(CMD_FEEDBACK, 11'h7ff, 2'd3, 13'h1fff, 16'hffff, 32'hffffffff);
		send(CMD_FEEDBACK, 11'd0, 2'd0, 13'd0, 16'd0, 32'd0);
		for (int md = 0; md < 4; md++) begin
			drain();
			write_reg(REG_LOOP_MODE, 16'(md));
			send(CMD_TICK, 11'd0, 2'd0, 13'd0, 16'd0, 32'h7fffffff);
			send(CMD_TICK, 11'h7ff, 2'd1, 13'h1fff, 16'hffff, 32'h80000000);
			send(CMD_TICK, 11'd0, 2'd3, 13'd0, 16'd0, 32'd0);
		end

		// Random phases over settings, extremes included
		for (int ph = 0; ph < 16; ph++) begin
			drain();
			write_reg(REG_LOOP_MODE, 16'(ph % 4));
			write_reg(REG_DRIVE_ENABLE, (ph % 5 == 4) ? 16'd0 : 16'd1);
			case (ph / 4)
				0: begin
					write_reg(REG_GAIN_PROP, 16'd3328);
					write_reg(REG_GAIN_INTEGRAL, 16'd1536);
					write_reg(REG_GAIN_DERIV, 16'd2560);
					write_reg(REG_GAIN_OUTER, 16'd3840);
				end
				1: begin
					write_reg(REG_GAIN_PROP, 16'hffff);
					write_reg(REG_GAIN_INTEGRAL, 16'hffff);
					write_reg(REG_GAIN_DERIV, 16'hffff);
					write_reg(REG_GAIN_OUTER, 16'hffff);
				end
				2: begin
					write_reg(REG_GAIN_PROP, 16'd0);
					write_reg(REG_GAIN_INTEGRAL, 16'd0);
					write_reg(REG_GAIN_DERIV, 16'd0);
					write_reg(REG_GAIN_OUTER, 16'd0);
				end
				default: begin
					write_reg(REG_GAIN_PROP, 16'($urandom));
					write_reg(REG_GAIN_INTEGRAL, 16'($urandom));
					write_reg(REG_GAIN_DERIV, 16'($urandom));
					write_reg(REG_GAIN_OUTER, 16'($urandom));
				end
			endcase
			for (int k = 0; k < 80; k++) begin
				if ($urandom_range(0, 1)) feedback_rand();
				else tick_rand();
			end
		end

		drain();
		$display("Covered %0d requests and %0d results over all four loop modes,",
			requests, board.results);
		$display("gain extremes, drive disable, bad ids and encoder wraps.");
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results missing", board.errors,
				board.pending.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

`default_nettype wire

>>> files.f
rtl/mmfc_pkg.sv
rtl/mmfc_mul.sv
rtl/mmfc_fsm.sv
rtl/multi_motor_feedback_and_current_loop.sv
verif/tb_multi_motor_feedback_and_current_loop.sv
